// ===== hdl/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg: shared types and constants of the motor command frame builder
// register map, request and result words, quantiser constants and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package mcfb_pkg;

  // default direction: forward
  localparam bit REVERSED_DEFAULT = 1'b0;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED         = 4'd0,
    REG_ZERO_OFFSET     = 4'd1,
    REG_OUTER_GAIN_P    = 4'd2,
    REG_OUTER_GAIN_I    = 4'd3,
    REG_FRAME_STIFFNESS = 4'd4,
    REG_FRAME_DAMPING   = 4'd5,
    REG_STEP_LIMIT      = 4'd6,
    REG_TORQUE_LIMIT    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               enabled;
    logic signed [31:0] zero_offset;
    logic [30:0]        outer_gain_p;
    logic [30:0]        outer_gain_i;
    logic [24:0]        frame_stiffness;
    logic [18:0]        frame_damping;
    logic [30:0]        step_limit;
    logic [30:0]        torque_limit;
  } cfg_t;

  // request selector codes, anything else is torque mode
  localparam logic [1:0] CMD_POS    = 2'd0;
  localparam logic [1:0] CMD_IDLE   = 2'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_vel;
    logic signed [31:0] torque_ff;
    logic signed [31:0] measured_pos;
  } cmd_req_t;

  typedef struct packed {
    logic        send;
    logic [63:0] frame_data;
    logic        err_first;
    logic        err_second;
  } frame_res_t;

  // frame ranges, Q16.16
  localparam int Q_ONE    = 65536;
  localparam int Q_P_MAX  = 6258688;
  localparam int Q_V_MAX  = 1474560;
  localparam int Q_KP_MAX = 32768000;
  localparam int Q_KD_MAX = 327680;
  localparam int Q_T_MAX  = 3538944;

  // each span is a whole multiple of one, so code = floor(floor(off*full/2^16)/d)
  localparam int D_P  = (2 * Q_P_MAX) / Q_ONE;
  localparam int D_V  = (2 * Q_V_MAX) / Q_ONE;
  localparam int D_KP = Q_KP_MAX / Q_ONE;
  localparam int D_KD = Q_KD_MAX / Q_ONE;
  localparam int D_T  = (2 * Q_T_MAX) / Q_ONE;

  // round-up reciprocals, exact for the scaled offsets below 2^25
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 33;
  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] R_P  = RECIP_W'((RECIP_ONE + D_P - 1) / D_P);
  localparam logic [RECIP_W-1:0] R_V  = RECIP_W'((RECIP_ONE + D_V - 1) / D_V);
  localparam logic [RECIP_W-1:0] R_KP = RECIP_W'((RECIP_ONE + D_KP - 1) / D_KP);
  localparam logic [RECIP_W-1:0] R_KD = RECIP_W'((RECIP_ONE + D_KD - 1) / D_KD);
  localparam logic [RECIP_W-1:0] R_T  = RECIP_W'((RECIP_ONE + D_T - 1) / D_T);

  typedef enum logic [2:0] {
    QF_P,
    QF_V,
    QF_KP,
    QF_KD,
    QF_T
  } qfield_e;

  localparam int QF_COUNT = 5;
  localparam int Q_CNT_W  = 3;
  // prep, multiply, store
  localparam int Q_PIPE   = 2;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_GP,
    MUL_GI,
    MUL_QUANT
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EP,
    ST_MP,
    ST_MI,
    ST_VC,
    ST_QUANT,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load_req;
    logic    calc_ep;
    logic    check;
    mul_op_e mul_op;
    logic    acc_load;
    logic    calc_v;
    logic    q_prep;
    qfield_e q_prep_f;
    logic    q_store;
    qfield_e q_store_f;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hdl/mcfb_regs.sv =====
// ----------------------------------------------------------------------------
// mcfb_regs: configuration register file
// eight registers written by index; unknown indexes are dropped
// ----------------------------------------------------------------------------
module mcfb_regs import mcfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled         <= 1'b0;
      cfg_q.zero_offset     <= '0;
      cfg_q.outer_gain_p    <= '0;
      cfg_q.outer_gain_i    <= '0;
      cfg_q.frame_stiffness <= '0;
      cfg_q.frame_damping   <= '0;
      cfg_q.step_limit      <= '1;
      cfg_q.torque_limit    <= '1;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENABLED:         cfg_q.enabled         <= cfg_data_i[0];
        REG_ZERO_OFFSET:     cfg_q.zero_offset     <= cfg_data_i;
        REG_OUTER_GAIN_P:    cfg_q.outer_gain_p    <= cfg_data_i[30:0];
        REG_OUTER_GAIN_I:    cfg_q.outer_gain_i    <= cfg_data_i[30:0];
        REG_FRAME_STIFFNESS: cfg_q.frame_stiffness <= cfg_data_i[24:0];
        REG_FRAME_DAMPING:   cfg_q.frame_damping   <= cfg_data_i[18:0];
        REG_STEP_LIMIT:      cfg_q.step_limit      <= cfg_data_i[30:0];
        REG_TORQUE_LIMIT:    cfg_q.torque_limit    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/mcfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcfb_ctrl: sequencer of the frame builder
// steps one word through error, gains, velocity and the five quantisers
// ----------------------------------------------------------------------------
module mcfb_ctrl import mcfb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [Q_CNT_W-1:0] CNT_PREP_END = Q_CNT_W'(QF_COUNT);
  localparam logic [Q_CNT_W-1:0] CNT_LAST     = Q_CNT_W'(QF_COUNT + Q_PIPE - 1);
  localparam logic [Q_CNT_W-1:0] CNT_PIPE     = Q_CNT_W'(Q_PIPE);

  ctrl_state_e state_q, state_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EP;
      ST_EP:    state_d = ST_MP;
      ST_MP:    state_d = ST_MI;
      ST_MI:    state_d = ST_VC;
      ST_VC:    state_d = ST_QUANT;
      ST_QUANT: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE:  if (!sts_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_op    = MUL_NONE;
    cmd_o.q_prep_f  = qfield_e'(cnt_q);
    cmd_o.q_store_f = qfield_e'(cnt_q - CNT_PIPE);
    in_stall_o      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_EP: cmd_o.calc_ep = 1'b1;
      ST_MP: begin
        cmd_o.check  = 1'b1;
        cmd_o.mul_op = MUL_GP;
      end
      ST_MI: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_op   = MUL_GI;
      end
      ST_VC: cmd_o.calc_v = 1'b1;
      ST_QUANT: begin
        cmd_o.q_prep  = (cnt_q < CNT_PREP_END);
        cmd_o.q_store = (cnt_q >= CNT_PIPE);
        if ((cnt_q != '0) && (cnt_q <= CNT_PREP_END)) begin
          cmd_o.mul_op = MUL_QUANT;
        end
      end
      ST_DONE: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hdl/mcfb_dpath.sv =====
// ----------------------------------------------------------------------------
// mcfb_dpath: datapath of the frame builder
// error and integrator, shared 33x33 multiplier, checks, quantisers, result
// ----------------------------------------------------------------------------
module mcfb_dpath import mcfb_pkg::*; #(
  parameter bit REVERSED = REVERSED_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_req_t   req_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output frame_res_t out_data_o
);

  localparam int QV_W  = 50;
  localparam int OFF_W = 25;
  localparam int SC_W  = OFF_W + 16;
  localparam int MUL_W = 33;

  localparam logic signed [34:0]     SAT_HI = 35'(32'sh7FFF_FFFF);
  localparam logic signed [34:0]     SAT_LO = 35'(32'sh8000_0000);
  localparam logic signed [32:0]     I_HI   = 33'(Q_ONE);
  localparam logic signed [32:0]     I_LO   = -I_HI;
  localparam logic signed [QV_W-1:0] P_HI   = QV_W'(Q_P_MAX);
  localparam logic signed [QV_W-1:0] V_HI   = QV_W'(Q_V_MAX);
  localparam logic signed [QV_W-1:0] KP_HI  = QV_W'(Q_KP_MAX);
  localparam logic signed [QV_W-1:0] KD_HI  = QV_W'(Q_KD_MAX);
  localparam logic signed [QV_W-1:0] T_HI   = QV_W'(Q_T_MAX);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > SAT_HI) begin
      sat32 = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      sat32 = SAT_LO[31:0];
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // request and mode
  cmd_req_t req_q;
  logic     pos_act_q, tor_act_q, is_pos_q;

  // state
  logic signed [17:0] integ_q;
  logic signed [31:0] last_q;
  logic [1:0]         sticky_q;

  // working registers
  logic signed [31:0]      ep_q, pcmd_q;
  logic signed [32:0]      tcmd_q;
  logic                    trip_step_q, trip_tor_q, trip_tmode_q;
  logic signed [63:0]      prod_q, acc_q;
  logic signed [QV_W-1:0]  vcmd_q;
  logic [OFF_W-1:0]        qx_q;
  logic [RECIP_W-1:0]      qr_q;
  logic [15:0]             p_code_q;
  logic [11:0]             v_code_q, kp_code_q, kd_code_q, t_code_q;
  frame_res_t              out_q;
  logic                    out_valid_q;

  // error, command position and torque
  logic signed [32:0] mpos_x, zo_x, mdiff, tff_x;
  logic signed [33:0] mdir, tdir, praw;
  logic signed [34:0] ep_raw;
  logic signed [31:0] ep_d, pcmd_d;
  logic signed [32:0] tcmd_d;

  always_comb begin
    mpos_x = 33'(req_q.measured_pos);
    zo_x   = 33'(cfg_i.zero_offset);
    tff_x  = 33'(req_q.torque_ff);
    mdiff  = mpos_x - zo_x;
    mdir   = REVERSED ? -34'(mdiff) : 34'(mdiff);
    ep_raw = 35'(req_q.target_pos) - 35'(mdir);
    ep_d   = sat32(ep_raw);
    tdir   = REVERSED ? -34'(req_q.target_pos) : 34'(req_q.target_pos);
    praw   = tdir + 34'(cfg_i.zero_offset);
    pcmd_d = sat32(35'(praw));
    tcmd_d = REVERSED ? -tff_x : tff_x;
  end

  // integrator and limit checks
  logic signed [32:0] isum, sdiff;
  logic signed [17:0] integ_d;
  logic [32:0]        sabs, tabs;
  logic               trip_step_d, trip_tor_d, trip_tmode_d;

  always_comb begin
    isum = 33'(integ_q) + 33'(ep_q);
    if (isum > I_HI) begin
      integ_d = I_HI[17:0];
    end else if (isum < I_LO) begin
      integ_d = I_LO[17:0];
    end else begin
      integ_d = isum[17:0];
    end
    sdiff        = 33'(pcmd_q) - 33'(last_q);
    sabs         = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    tabs         = tcmd_q[32] ? 33'(-tcmd_q) : 33'(tcmd_q);
    trip_step_d  = sabs >= 33'(cfg_i.step_limit);
    trip_tor_d   = cfg_i.torque_limit == '0;
    trip_tmode_d = tabs >= 33'(cfg_i.torque_limit);
  end

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_GP: begin
        mul_a = signed'({2'b00, cfg_i.outer_gain_p});
        mul_b = 33'(ep_q);
      end
      MUL_GI: begin
        mul_a = signed'({2'b00, cfg_i.outer_gain_i});
        mul_b = 33'(integ_q);
      end
      MUL_QUANT: begin
        mul_a = signed'({8'b0, qx_q});
        mul_b = signed'(qr_q);
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // velocity: target_vel rides in the accumulator at Q32 so one shift floors both
  logic signed [63:0] tvel_sh, vsum;
  logic signed [47:0] vfl;

  always_comb begin
    tvel_sh = {{16{req_q.target_vel[31]}}, req_q.target_vel, 16'b0};
    vsum    = acc_q + prod_q;
    vfl     = vsum[63:16];
  end

  // quantiser operand: clamp, offset, scale by full code
  logic signed [QV_W-1:0] qval, qlo, qhi, qdiff;
  logic                   qwide;
  logic [RECIP_W-1:0]     qrec;
  logic [OFF_W-1:0]       qoff;
  logic [SC_W-1:0]        qoff_x, qsc;

  always_comb begin
    qval  = '0;
    qlo   = '0;
    qhi   = '0;
    qwide = 1'b0;
    qrec  = '0;
    unique case (cmd_i.q_prep_f)
      QF_P: begin
        qval  = is_pos_q ? QV_W'(pcmd_q) : '0;
        qlo   = -P_HI;
        qhi   = P_HI;
        qwide = 1'b1;
        qrec  = R_P;
      end
      QF_V: begin
        qval = is_pos_q ? vcmd_q : '0;
        qlo  = -V_HI;
        qhi  = V_HI;
        qrec = R_V;
      end
      QF_KP: begin
        qval = is_pos_q ? QV_W'(signed'({1'b0, cfg_i.frame_stiffness})) : '0;
        qhi  = KP_HI;
        qrec = R_KP;
      end
      QF_KD: begin
        qval = is_pos_q ? QV_W'(signed'({1'b0, cfg_i.frame_damping})) : '0;
        qhi  = KD_HI;
        qrec = R_KD;
      end
      QF_T: begin
        qval = is_pos_q ? '0 : QV_W'(tcmd_q);
        qlo  = -T_HI;
        qhi  = T_HI;
        qrec = R_T;
      end
      default: ;
    endcase
    if (qval < qlo) begin
      qdiff = '0;
    end else if (qval > qhi) begin
      qdiff = qhi - qlo;
    end else begin
      qdiff = qval - qlo;
    end
    qoff   = qdiff[OFF_W-1:0];
    qoff_x = SC_W'(qoff);
    qsc    = qwide ? (qoff_x << 16) - qoff_x : (qoff_x << 12) - qoff_x;
  end

  // result assembly
  logic       send;
  logic [1:0] sticky_d;

  always_comb begin
    send = (pos_act_q & ~trip_step_q & ~trip_tor_q) | (tor_act_q & ~trip_tmode_q);
    sticky_d = sticky_q | {pos_act_q & trip_tor_q,
                           (pos_act_q & trip_step_q) | (tor_act_q & trip_tmode_q)};
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.calc_ep) begin
      ep_q   <= ep_d;
      pcmd_q <= pcmd_d;
      tcmd_q <= tcmd_d;
    end
    if (cmd_i.check) begin
      trip_step_q  <= trip_step_d;
      trip_tor_q   <= trip_tor_d;
      trip_tmode_q <= trip_tmode_d;
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= mul_p[63:0];
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q + tvel_sh;
    end
    if (cmd_i.calc_v) begin
      vcmd_q <= REVERSED ? -QV_W'(vfl) : QV_W'(vfl);
    end
    if (cmd_i.q_prep) begin
      qx_q <= qsc[SC_W-1:16];
      qr_q <= qrec;
    end
    if (cmd_i.q_store) begin
      case (cmd_i.q_store_f)
        QF_P:    p_code_q  <= prod_q[RECIP_SHIFT +: 16];
        QF_V:    v_code_q  <= prod_q[RECIP_SHIFT +: 12];
        QF_KP:   kp_code_q <= prod_q[RECIP_SHIFT +: 12];
        QF_KD:   kd_code_q <= prod_q[RECIP_SHIFT +: 12];
        QF_T:    t_code_q  <= prod_q[RECIP_SHIFT +: 12];
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.send       <= send;
      out_q.frame_data <= send ? {p_code_q, v_code_q, kp_code_q, kd_code_q, t_code_q}
                               : '0;
      out_q.err_first  <= sticky_d[0];
      out_q.err_second <= sticky_d[1];
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_act_q   <= 1'b0;
      tor_act_q   <= 1'b0;
      is_pos_q    <= 1'b0;
      integ_q     <= '0;
      last_q      <= '0;
      sticky_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        is_pos_q  <= req_i.cmd == CMD_POS;
        pos_act_q <= cfg_i.enabled & (req_i.cmd == CMD_POS);
        tor_act_q <= cfg_i.enabled & (req_i.cmd != CMD_POS) & (req_i.cmd != CMD_IDLE);
      end
      // integrator moves even when the command is refused
      if (cmd_i.check && pos_act_q) begin
        integ_q <= integ_d;
      end
      if (cmd_i.out_load) begin
        sticky_q <= sticky_d;
        if (send) begin
          last_q <= is_pos_q ? pcmd_q : req_q.measured_pos;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== hdl/motor_command_frame_builder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_builder: position PI / torque command to 8-byte motor frame
// flow: one request in flight; the next is taken once its result word is registered,
//   which waits while an earlier result word is still stalled downstream
// multiplier: one shared 33x33 unit for the two gain products and five quantisers
// reset: asynchronous active low; registers to defaults, state and flags cleared
// ----------------------------------------------------------------------------
module motor_command_frame_builder import mcfb_pkg::*; #(
  parameter bit REVERSED = REVERSED_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cmd_req_t              in_data_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output frame_res_t            out_data_o
);

  // register file feeds the datapath directly
  cfg_t    cfg;
  // sequencer commands and datapath status
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // register file; always ready, indexes past the map are dropped
  mcfb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: one request word in flight; stall is released only in idle,
  // and the finished word waits in the output register so the next request
  // can be taken while the previous result is still stalled downstream
  mcfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // datapath: error and integrator, gain products, velocity, checks,
  // quantisers by reciprocal multiply, frame packing and sticky flags
  mcfb_dpath #(
    .REVERSED (REVERSED)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/mcfb_checker.sv =====
// ----------------------------------------------------------------------------
// mcfb_checker: port-level checks of the frame builder
// one request at a time, held results, sticky flags, no unprompted results
// ----------------------------------------------------------------------------
module mcfb_checker import mcfb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input frame_res_t out_data_o
);

  // a taken request closes the input until its result is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // sticky flags never drop between shown words
  a_sticky_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.err_first) ##1 out_valid_o |-> out_data_o.err_first)
    else $error("err_first cleared");

  a_sticky_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.err_second) ##1 out_valid_o |-> out_data_o.err_second)
    else $error("err_second cleared");

  // a new result only follows a request being worked on
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without request");

endmodule

bind motor_command_frame_builder mcfb_checker u_checker (.*);
